### rtl/bmf_pkg.sv
// ----------------------------------------------------------------------------
// bmf_pkg: shared definitions for the Bode margin finder
// Field widths, phase constants and the request passed to the shared
// interpolation unit.
// ----------------------------------------------------------------------------
package bmf_pkg;

    // Field widths of the sweep and result beats.
    localparam int LF_W   = 24;
    localparam int MAG_W  = 24;
    localparam int PH_W   = 15;
    localparam int UNW_W  = 23;
    localparam int TURN_W = 8;

    // Phase constants in 1/64 degree units.
    localparam int TURN_UNITS = 23040;
    localparam int HALF_TURN  = 11520;
    localparam int TURN_LIMIT = 127;
    localparam int GAIN_MAX   = 8388607;

    // Width of the unwrap step difference.
    localparam int DIFF_W = 25;

    // Interpolation operand and result widths.
    localparam int A_W    = 24;
    localparam int Y_W    = 25;
    localparam int PROD_W = Y_W + A_W + 1;
    localparam int Q_W    = A_W + 1;
    localparam int DEN_W  = PROD_W - Q_W;

    // Operands of one interpolation: a0 + y0 * (a1 - a0) / (y0 - y1).
    typedef struct packed {
        logic signed [A_W-1:0] a0;
        logic signed [A_W-1:0] a1;
        logic signed [Y_W-1:0] y0;
        logic signed [Y_W-1:0] y1;
    } interp_req_t;

endpackage

### rtl/bmf_if.sv
// ----------------------------------------------------------------------------
// bmf_if: valid/ready channels of the Bode margin finder
// One interface for the sweep samples and one for the margin results.
// ----------------------------------------------------------------------------
interface bmf_in_if;
    import bmf_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [LF_W-1:0]  log_freq;
    logic signed [MAG_W-1:0] mag_db;
    logic signed [PH_W-1:0]  phase_deg;
    logic                    last_sample;

    modport source (output valid, log_freq, mag_db, phase_deg, last_sample, input ready);
    modport sink   (input valid, log_freq, mag_db, phase_deg, last_sample, output ready);
endinterface

interface bmf_out_if;
    import bmf_pkg::*;

    logic                    valid;
    logic                    ready;
    logic                    gain_margin_found;
    logic signed [LF_W-1:0]  gain_margin_log_freq;
    logic signed [MAG_W-1:0] gain_margin_db;
    logic                    phase_margin_found;
    logic signed [LF_W-1:0]  phase_margin_log_freq;
    logic signed [UNW_W-1:0] phase_margin_deg;
    logic                    stable;

    modport source (output valid, gain_margin_found, gain_margin_log_freq, gain_margin_db,
                    phase_margin_found, phase_margin_log_freq, phase_margin_deg, stable,
                    input ready);
    modport sink   (input valid, gain_margin_found, gain_margin_log_freq, gain_margin_db,
                    phase_margin_found, phase_margin_log_freq, phase_margin_deg, stable,
                    output ready);
endinterface

### rtl/bmf_interp.sv
// ----------------------------------------------------------------------------
// bmf_interp: shared linear interpolation unit
// Computes a0 + round(y0 * (a1 - a0) / (y0 - y1)), rounding half away from
// zero, with a multiply step and a restoring divider of one bit a cycle.
// ----------------------------------------------------------------------------
module bmf_interp (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  bmf_pkg::interp_req_t          req,
    output logic                          done,
    output logic signed [bmf_pkg::A_W-1:0] result
);
    import bmf_pkg::*;

    localparam int CNT_W = $clog2(Q_W);

    typedef enum logic [2:0] {
        I_IDLE,
        I_MUL,
        I_ABS,
        I_ADD,
        I_DIV,
        I_FIX
    } istate_t;

    istate_t                 state_reg;
    logic                    done_reg;
    logic signed [A_W-1:0]   result_reg;
    logic [CNT_W-1:0]        cnt_reg;

    logic signed [A_W-1:0]   a0_reg;
    logic signed [Y_W-1:0]   y0_reg;
    logic signed [A_W:0]     dif_reg;
    logic signed [Y_W:0]     den_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic                    neg_reg;
    logic [DEN_W-1:0]        denm_reg;
    logic [PROD_W-1:0]       mag_reg;
    logic [DEN_W-1:0]        rem_reg;
    logic [Q_W-1:0]          quo_reg;

    logic signed [PROD_W-1:0] prod_c;
    logic signed [Y_W:0]      den_abs_c;
    logic [PROD_W-1:0]        sum_c;
    logic [DEN_W:0]           trial_c;
    logic [DEN_W:0]           trial_sub_c;
    logic                     ge_c;
    logic signed [Q_W:0]      qs_c;
    logic signed [Q_W:0]      res_c;

    // Product and divisor magnitude.
    assign prod_c    = y0_reg * dif_reg;
    assign den_abs_c = den_reg[Y_W] ? -den_reg : den_reg;

    // Rounding bias: half the divisor is added before truncating division.
    assign sum_c = mag_reg + PROD_W'(denm_reg >> 1);

    // One restoring division step; dividend bits shift out of the quotient.
    assign trial_c     = {rem_reg, quo_reg[Q_W-1]};
    assign trial_sub_c = trial_c - {1'b0, denm_reg};
    assign ge_c        = (trial_c >= {1'b0, denm_reg});

    // Signed quotient added back to the start point.
    assign qs_c  = neg_reg ? -$signed({1'b0, quo_reg}) : $signed({1'b0, quo_reg});
    assign res_c = (Q_W+1)'(a0_reg) + qs_c;

    // Sequencer and registered outputs.
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg  <= I_IDLE;
            done_reg   <= 1'b0;
            result_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            done_reg <= 1'b0;
            case (state_reg)
                I_IDLE: begin
                    if (start) begin
                        state_reg <= I_MUL;
                    end
                end
                I_MUL: begin
                    state_reg <= I_ABS;
                end
                I_ABS: begin
                    state_reg <= I_ADD;
                end
                I_ADD: begin
                    cnt_reg   <= '0;
                    state_reg <= I_DIV;
                end
                I_DIV: begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CNT_W'(Q_W - 1)) begin
                        state_reg <= I_FIX;
                    end
                end
                I_FIX: begin
                    result_reg <= res_c[A_W-1:0];
                    done_reg   <= 1'b1;
                    state_reg  <= I_IDLE;
                end
                default: begin
                    state_reg <= I_IDLE;
                end
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge clk) begin
        case (state_reg)
            I_IDLE: begin
                if (start) begin
                    a0_reg  <= req.a0;
                    y0_reg  <= req.y0;
                    dif_reg <= (A_W+1)'(req.a1) - (A_W+1)'(req.a0);
                    den_reg <= (Y_W+1)'(req.y0) - (Y_W+1)'(req.y1);
                end
            end
            I_MUL: begin
                prod_reg <= prod_c;
                neg_reg  <= y0_reg[Y_W-1] ^ dif_reg[A_W] ^ den_reg[Y_W];
                denm_reg <= den_abs_c[DEN_W-1:0];
            end
            I_ABS: begin
                mag_reg <= prod_reg[PROD_W-1] ? PROD_W'(-prod_reg) : PROD_W'(prod_reg);
            end
            I_ADD: begin
                rem_reg <= sum_c[PROD_W-1:Q_W];
                quo_reg <= sum_c[Q_W-1:0];
            end
            I_DIV: begin
                rem_reg <= ge_c ? trial_sub_c[DEN_W-1:0] : trial_c[DEN_W-1:0];
                quo_reg <= {quo_reg[Q_W-2:0], ge_c};
            end
            default: begin
            end
        endcase
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

### rtl/bode_margin_finder.sv
// ----------------------------------------------------------------------------
// bode_margin_finder: gain and phase margin from a frequency sweep
// Unwraps the phase, finds the first -180 degree phase crossing and the first
// 0 dB magnitude crossing, and reports both margins on the last sample.
// ----------------------------------------------------------------------------
// The block takes one sweep beat at a time and is not ready again until that
// beat is done. The phase unwrap corrects the turn count one 360 degree turn
// at a time, and each interpolation runs in the shared multiply and serial
// divide unit, which produces one quotient bit a cycle; a beat where both
// margins are interpolated uses it four times. A last sample then hands the
// result to the output register once that register is free, which holds it
// until taken, and clears the sweep state for the next sweep.
// ----------------------------------------------------------------------------
module bode_margin_finder (
    input  logic       clk,
    input  logic       rst_n,
    bmf_in_if.sink     sweep,
    bmf_out_if.source  margins
);
    import bmf_pkg::*;

    localparam logic signed [DIFF_W-1:0] HALF_D     = DIFF_W'(HALF_TURN);
    localparam logic signed [DIFF_W-1:0] NEG_HALF_D = DIFF_W'(-HALF_TURN);
    localparam logic signed [DIFF_W-1:0] TURN_D     = DIFF_W'(TURN_UNITS);
    localparam logic signed [TURN_W-1:0] TURN_MAX   = TURN_W'(TURN_LIMIT);
    localparam logic signed [TURN_W-1:0] TURN_MIN   = TURN_W'(-TURN_LIMIT);

    typedef enum logic [3:0] {
        S_IDLE,
        S_UNWRAP,
        S_UNW,
        S_GM_CHK,
        S_GM_FREQ,
        S_GM_VAL,
        S_PM_CHK,
        S_PM_FREQ,
        S_PM_VAL,
        S_COMMIT,
        S_EMIT
    } state_t;

    // Sweep state.
    state_t                   state_reg;
    logic                     have_prev_reg;
    logic signed [TURN_W-1:0] turn_reg;
    logic signed [LF_W-1:0]   prev_lf_reg;
    logic signed [MAG_W-1:0]  prev_mag_reg;
    logic signed [UNW_W-1:0]  prev_unw_reg;
    logic                     gm_found_reg;
    logic signed [LF_W-1:0]   gm_freq_reg;
    logic signed [MAG_W-1:0]  gm_val_reg;
    logic                     pm_found_reg;
    logic signed [LF_W-1:0]   pm_freq_reg;
    logic signed [UNW_W-1:0]  pm_val_reg;

    // Output register.
    logic                     out_valid_reg;
    logic                     out_gm_found_reg;
    logic signed [LF_W-1:0]   out_gm_freq_reg;
    logic signed [MAG_W-1:0]  out_gm_db_reg;
    logic                     out_pm_found_reg;
    logic signed [LF_W-1:0]   out_pm_freq_reg;
    logic signed [UNW_W-1:0]  out_pm_deg_reg;
    logic                     out_stable_reg;

    // Current beat.
    logic signed [LF_W-1:0]   lf_reg;
    logic signed [MAG_W-1:0]  mg_reg;
    logic signed [PH_W-1:0]   ph_reg;
    logic                     last_reg;
    logic signed [DIFF_W-1:0] diff_reg;
    logic signed [UNW_W-1:0]  unw_reg;

    logic                     accept;
    logic signed [UNW_W-1:0]  turn_units_c;
    logic                     unw_down;
    logic                     unw_up;
    logic signed [Y_W-1:0]    gm_y0;
    logic signed [Y_W-1:0]    gm_y1;
    logic signed [Y_W-1:0]    pm_y0;
    logic signed [Y_W-1:0]    pm_y1;
    logic                     gm_try;
    logic                     pm_try;
    logic                     gm_zero;
    logic                     pm_zero;
    logic                     gm_cross;
    logic                     pm_cross;
    logic                     ip_start;
    interp_req_t              ip_req;
    logic                     ip_done;
    logic signed [A_W-1:0]    ip_result;
    logic                     gain_ok;
    logic                     phase_ok;
    logic                     emit_load;

    // Sign change from a nonzero first offset to a second offset of the other sign or zero.
    function automatic logic crosses(input logic signed [Y_W-1:0] y0,
                                     input logic signed [Y_W-1:0] y1);
        return ((y0 > 0) && (y1 <= 0)) || ((y0 < 0) && (y1 >= 0));
    endfunction

    // Negated magnitude, saturated at the positive limit.
    function automatic logic signed [MAG_W-1:0] gain_of(input logic signed [A_W-1:0] o);
        logic signed [A_W:0] n;
        n = -((A_W+1)'(o));
        if (n > (A_W+1)'(GAIN_MAX)) begin
            return MAG_W'(GAIN_MAX);
        end
        return n[MAG_W-1:0];
    endfunction

    // 180 degrees plus an unwrapped phase.
    function automatic logic signed [UNW_W-1:0] margin_of(input logic signed [A_W-1:0] o);
        logic signed [A_W:0] s;
        s = (A_W+1)'(o) + (A_W+1)'(HALF_TURN);
        return s[UNW_W-1:0];
    endfunction

    assign accept       = sweep.valid && sweep.ready;
    assign sweep.ready  = (state_reg == S_IDLE);
    assign turn_units_c = UNW_W'(turn_reg) * UNW_W'(TURN_UNITS);

    // Unwrap steps: one turn a cycle until the step is within half a turn or the turn count is at its limit.
    assign unw_down = (state_reg == S_UNWRAP) && have_prev_reg &&
                      (diff_reg > HALF_D) && (turn_reg != TURN_MIN);
    assign unw_up   = (state_reg == S_UNWRAP) && have_prev_reg &&
                      (diff_reg < NEG_HALF_D) && (turn_reg != TURN_MAX);

    // Crossing tests against -180 degrees and 0 dB.
    assign gm_y0    = Y_W'(prev_unw_reg) + Y_W'(HALF_TURN);
    assign gm_y1    = Y_W'(unw_reg) + Y_W'(HALF_TURN);
    assign pm_y0    = Y_W'(prev_mag_reg);
    assign pm_y1    = Y_W'(mg_reg);
    assign gm_try   = have_prev_reg && !gm_found_reg;
    assign pm_try   = have_prev_reg && !pm_found_reg;
    assign gm_zero  = (gm_y0 == '0);
    assign pm_zero  = (pm_y0 == '0);
    assign gm_cross = crosses(gm_y0, gm_y1);
    assign pm_cross = crosses(pm_y0, pm_y1);

    // Requests to the shared interpolation unit.
    always_comb begin
        ip_start  = 1'b0;
        ip_req.a0 = A_W'(prev_lf_reg);
        ip_req.a1 = A_W'(lf_reg);
        ip_req.y0 = gm_y0;
        ip_req.y1 = gm_y1;
        case (state_reg)
            S_GM_CHK: begin
                ip_start = gm_try && !gm_zero && gm_cross;
            end
            S_GM_FREQ: begin
                ip_req.a0 = A_W'(prev_mag_reg);
                ip_req.a1 = A_W'(mg_reg);
                ip_start  = ip_done;
            end
            S_PM_CHK: begin
                ip_req.y0 = pm_y0;
                ip_req.y1 = pm_y1;
                ip_start  = pm_try && !pm_zero && pm_cross;
            end
            S_PM_FREQ: begin
                ip_req.a0 = A_W'(prev_unw_reg);
                ip_req.a1 = A_W'(unw_reg);
                ip_req.y0 = pm_y0;
                ip_req.y1 = pm_y1;
                ip_start  = ip_done;
            end
            default: begin
            end
        endcase
    end

    bmf_interp u_interp (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (ip_start),
        .req    (ip_req),
        .done   (ip_done),
        .result (ip_result)
    );

    // Stability: every margin that was found must be positive.
    assign gain_ok   = !gm_found_reg || (gm_val_reg > 0);
    assign phase_ok  = !pm_found_reg || (pm_val_reg > 0);
    assign emit_load = (state_reg == S_EMIT) && (!out_valid_reg || margins.ready);

    // Sequencer, sweep state and output register.
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg        <= S_IDLE;
            have_prev_reg    <= 1'b0;
            turn_reg         <= '0;
            prev_lf_reg      <= '0;
            prev_mag_reg     <= '0;
            prev_unw_reg     <= '0;
            gm_found_reg     <= 1'b0;
            gm_freq_reg      <= '0;
            gm_val_reg       <= '0;
            pm_found_reg     <= 1'b0;
            pm_freq_reg      <= '0;
            pm_val_reg       <= '0;
            out_valid_reg    <= 1'b0;
            out_gm_found_reg <= 1'b0;
            out_gm_freq_reg  <= '0;
            out_gm_db_reg    <= '0;
            out_pm_found_reg <= 1'b0;
            out_pm_freq_reg  <= '0;
            out_pm_deg_reg   <= '0;
            out_stable_reg   <= 1'b0;
        end else begin
            if (out_valid_reg && margins.ready && !emit_load) begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        state_reg <= S_UNWRAP;
                    end
                end
                S_UNWRAP: begin
                    if (unw_down) begin
                        turn_reg <= turn_reg - 1'b1;
                    end else if (unw_up) begin
                        turn_reg <= turn_reg + 1'b1;
                    end else begin
                        state_reg <= S_UNW;
                    end
                end
                S_UNW: begin
                    state_reg <= S_GM_CHK;
                end
                S_GM_CHK: begin
                    if (gm_try && gm_zero) begin
                        gm_found_reg <= 1'b1;
                        gm_freq_reg  <= prev_lf_reg;
                        gm_val_reg   <= gain_of(A_W'(prev_mag_reg));
                        state_reg    <= S_PM_CHK;
                    end else if (ip_start) begin
                        state_reg <= S_GM_FREQ;
                    end else begin
                        state_reg <= S_PM_CHK;
                    end
                end
                S_GM_FREQ: begin
                    if (ip_done) begin
                        gm_freq_reg <= LF_W'(ip_result);
                        state_reg   <= S_GM_VAL;
                    end
                end
                S_GM_VAL: begin
                    if (ip_done) begin
                        gm_found_reg <= 1'b1;
                        gm_val_reg   <= gain_of(ip_result);
                        state_reg    <= S_PM_CHK;
                    end
                end
                S_PM_CHK: begin
                    if (pm_try && pm_zero) begin
                        pm_found_reg <= 1'b1;
                        pm_freq_reg  <= prev_lf_reg;
                        pm_val_reg   <= margin_of(A_W'(prev_unw_reg));
                        state_reg    <= S_COMMIT;
                    end else if (ip_start) begin
                        state_reg <= S_PM_FREQ;
                    end else begin
                        state_reg <= S_COMMIT;
                    end
                end
                S_PM_FREQ: begin
                    if (ip_done) begin
                        pm_freq_reg <= LF_W'(ip_result);
                        state_reg   <= S_PM_VAL;
                    end
                end
                S_PM_VAL: begin
                    if (ip_done) begin
                        pm_found_reg <= 1'b1;
                        pm_val_reg   <= margin_of(ip_result);
                        state_reg    <= S_COMMIT;
                    end
                end
                S_COMMIT: begin
                    have_prev_reg <= 1'b1;
                    prev_lf_reg   <= lf_reg;
                    prev_mag_reg  <= mg_reg;
                    prev_unw_reg  <= unw_reg;
                    state_reg     <= last_reg ? S_EMIT : S_IDLE;
                end
                S_EMIT: begin
                    if (emit_load) begin
                        out_valid_reg    <= 1'b1;
                        out_gm_found_reg <= gm_found_reg;
                        out_gm_freq_reg  <= gm_freq_reg;
                        out_gm_db_reg    <= gm_val_reg;
                        out_pm_found_reg <= pm_found_reg;
                        out_pm_freq_reg  <= pm_freq_reg;
                        out_pm_deg_reg   <= pm_val_reg;
                        out_stable_reg   <= gain_ok && phase_ok;
                        have_prev_reg    <= 1'b0;
                        turn_reg         <= '0;
                        prev_lf_reg      <= '0;
                        prev_mag_reg     <= '0;
                        prev_unw_reg     <= '0;
                        gm_found_reg     <= 1'b0;
                        gm_freq_reg      <= '0;
                        gm_val_reg       <= '0;
                        pm_found_reg     <= 1'b0;
                        pm_freq_reg      <= '0;
                        pm_val_reg       <= '0;
                        state_reg        <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Beat capture, unwrap difference and unwrapped phase.
    always_ff @(posedge clk) begin
        if (accept) begin
            lf_reg   <= sweep.log_freq;
            mg_reg   <= sweep.mag_db;
            ph_reg   <= sweep.phase_deg;
            last_reg <= sweep.last_sample;
            diff_reg <= DIFF_W'(sweep.phase_deg) + DIFF_W'(turn_units_c) -
                        DIFF_W'(prev_unw_reg);
        end else if (unw_down) begin
            diff_reg <= diff_reg - TURN_D;
        end else if (unw_up) begin
            diff_reg <= diff_reg + TURN_D;
        end
        if (state_reg == S_UNW) begin
            unw_reg <= UNW_W'(ph_reg) + turn_units_c;
        end
    end

    assign margins.valid                 = out_valid_reg;
    assign margins.gain_margin_found     = out_gm_found_reg;
    assign margins.gain_margin_log_freq  = out_gm_freq_reg;
    assign margins.gain_margin_db        = out_gm_db_reg;
    assign margins.phase_margin_found    = out_pm_found_reg;
    assign margins.phase_margin_log_freq = out_pm_freq_reg;
    assign margins.phase_margin_deg      = out_pm_deg_reg;
    assign margins.stable                = out_stable_reg;

endmodule

### rtl/bmf_checker.sv
// ----------------------------------------------------------------------------
// bmf_checker: port-level checks for the Bode margin finder
// Watches the sweep and margin channels and is bound to the top level.
// ----------------------------------------------------------------------------
module bmf_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                sweep_valid,
    input logic                                sweep_ready,
    input logic                                margins_valid,
    input logic                                margins_ready,
    input logic                                gm_found,
    input logic signed [bmf_pkg::LF_W-1:0]     gm_freq,
    input logic signed [bmf_pkg::MAG_W-1:0]    gm_db,
    input logic                                pm_found,
    input logic signed [bmf_pkg::LF_W-1:0]     pm_freq,
    input logic signed [bmf_pkg::UNW_W-1:0]    pm_deg,
    input logic                                stable
);
    import bmf_pkg::*;

    // A result beat that is not taken stays put.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        margins_valid && !margins_ready |=>
            margins_valid && $stable(gm_db) && $stable(pm_deg) && $stable(stable))
        else $error("margin beat changed while stalled");

    // The block leaves its idle state on an accept, so ready drops after it.
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        sweep_valid && sweep_ready |=> !sweep_ready)
        else $error("sweep accepted on back-to-back cycles");

    // The stable flag agrees with the reported margins.
    a_stable: assert property (@(posedge clk) disable iff (!rst_n)
        margins_valid |->
            stable == ((!gm_found || (gm_db > 0)) && (!pm_found || (pm_deg > 0))))
        else $error("stable flag does not match the margins");

    // A margin that was not found reports zero fields.
    a_not_found: assert property (@(posedge clk) disable iff (!rst_n)
        margins_valid |->
            (gm_found || ((gm_freq == 0) && (gm_db == 0))) &&
            (pm_found || ((pm_freq == 0) && (pm_deg == 0))))
        else $error("fields of a missing margin are not zero");

endmodule

bind bode_margin_finder bmf_checker u_bmf_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .sweep_valid   (sweep.valid),
    .sweep_ready   (sweep.ready),
    .margins_valid (margins.valid),
    .margins_ready (margins.ready),
    .gm_found      (margins.gain_margin_found),
    .gm_freq       (margins.gain_margin_log_freq),
    .gm_db         (margins.gain_margin_db),
    .pm_found      (margins.phase_margin_found),
    .pm_freq       (margins.phase_margin_log_freq),
    .pm_deg        (margins.phase_margin_deg),
    .stable        (margins.stable)
);

### tb/tb_bode_margin_finder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bode_margin_finder: self-checking bench for the Bode margin finder
// Drives frequency sweeps into the block, predicts the margin report of each
// sweep with a behavioral copy of the unwrap and crossing search, and checks
// every report beat field by field. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_bode_margin_finder;
    import bmf_pkg::*;

    // One sweep sample as it is driven onto the input channel.
    typedef struct packed {
        logic signed [LF_W-1:0]  log_freq;
        logic signed [MAG_W-1:0] mag_db;
        logic signed [PH_W-1:0]  phase_deg;
        logic                    last_sample;
    } sweep_sample_t;

    // One margin report as it leaves the block.
    typedef struct packed {
        logic                    gm_found;
        logic signed [LF_W-1:0]  gm_log_freq;
        logic signed [MAG_W-1:0] gm_db;
        logic                    pm_found;
        logic signed [LF_W-1:0]  pm_log_freq;
        logic signed [UNW_W-1:0] pm_deg;
        logic                    stable;
    } margin_report_t;

    localparam int  CYCLE_LIMIT   = 3000000;
    localparam int  SETTLE_CYCLES = 400;
    localparam int  FIRST_BATCH   = 650;
    localparam int  RANDOM_ITEMS  = 1450;
    localparam int  SPIRAL_LEN    = 290;
    localparam longint FIELD24_MIN = -8388608;
    localparam longint FIELD24_MAX = 8388607;
    localparam longint PHASE_MIN   = -16384;
    localparam longint PHASE_MAX   = 16383;

    logic clk;
    logic rst_n;

    bmf_in_if  sweep_ch ();
    bmf_out_if report_ch ();

    bode_margin_finder DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .sweep   (sweep_ch),
        .margins (report_ch)
    );

    // Stimulus and expectation stores.
    sweep_sample_t  pending_samples[$];
    margin_report_t expected_reports[$];
    sweep_sample_t  next_sample;
    margin_report_t seen_report;
    sweep_sample_t  taken_sample;

    // Predicted sweep state.
    bit     sw_started;
    longint sw_prev_freq;
    longint sw_prev_mag;
    longint sw_prev_phase;
    int     sw_turns;
    bit     gm_hit;
    longint gm_freq;
    longint gm_db;
    bit     pm_hit;
    longint pm_freq;
    longint pm_deg;

    // Bookkeeping.
    int error_count;
    int samples_queued;
    int samples_taken;
    int random_queued;
    int reports_checked;
    int gm_reports;
    int pm_reports;
    int unstable_reports;
    int turn_limit_samples;
    int cycle_count;
    bit beat_taken;
    int gap_left;
    int stall_left;
    int calm_in;
    int calm_out;

    // Clock.
    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Uniform random value in [lo, hi].
    function automatic longint rnd(longint lo, longint hi);
        return lo + longint'($urandom_range(0, int'(hi - lo)));
    endfunction

    function automatic longint clamp(longint v, longint lo, longint hi);
        if (v < lo)
            return lo;
        if (v > hi)
            return hi;
        return v;
    endfunction

    // Folds an unwrapped phase back into the principal range.
    function automatic longint principal(longint x);
        while (x > HALF_TURN)
            x -= TURN_UNITS;
        while (x < -HALF_TURN)
            x += TURN_UNITS;
        return x;
    endfunction

    // Idle length for one side: mostly none or short, a few long, and now and
    // then a calm stretch with no idling at all.
    function automatic int pick_idle(inout int calm);
        int r;
        if (calm > 0) begin
            calm--;
            return 0;
        end
        r = int'(rnd(0, 99));
        if (r < 2) begin
            calm = int'(rnd(20, 80));
            return 0;
        end
        if (r < 50)
            return 0;
        if (r < 85)
            return int'(rnd(1, 3));
        if (r < 97)
            return int'(rnd(4, 12));
        return int'(rnd(20, 60));
    endfunction

    // a0 + y0 * (a1 - a0) / (y0 - y1), rounded to nearest, ties away from zero.
    function automatic longint lerp_round(longint a0, longint a1, longint y0, longint y1);
        longint num;
        longint den;
        longint mag;
        longint q;
        num = y0 * (a1 - a0);
        den = y0 - y1;
        if (den < 0) begin
            den = -den;
            num = -num;
        end
        mag = (num < 0) ? -num : num;
        q = (mag + den / 2) / den;
        if (num < 0)
            q = -q;
        return a0 + q;
    endfunction

    // Crossing of target between two samples; an exact hit on the earlier
    // sample is taken as is.
    function automatic bit find_cross(input longint s0, s1, target, f0, f1, o0, o1,
                                      output longint freq, output longint other);
        longint y0;
        longint y1;
        y0 = s0 - target;
        y1 = s1 - target;
        freq = 0;
        other = 0;
        if (y0 == 0) begin
            freq = f0;
            other = o0;
            return 1'b1;
        end
        if (!((y0 > 0 && y1 <= 0) || (y0 < 0 && y1 >= 0)))
            return 1'b0;
        freq = lerp_round(f0, f1, y0, y1);
        other = lerp_round(o0, o1, y0, y1);
        return 1'b1;
    endfunction

    function automatic void clear_sweep();
        sw_started = 1'b0;
        sw_prev_freq = 0;
        sw_prev_mag = 0;
        sw_prev_phase = 0;
        sw_turns = 0;
        gm_hit = 1'b0;
        gm_freq = 0;
        gm_db = 0;
        pm_hit = 1'b0;
        pm_freq = 0;
        pm_deg = 0;
    endfunction

    // Advances the predicted sweep by one accepted sample and queues the
    // margin report when the sample closes the sweep.
    task automatic track_sweep_sample(input sweep_sample_t s);
        longint ph;
        longint lf;
        longint mg;
        longint diff;
        longint unw;
        longint f;
        longint o;
        longint g;
        margin_report_t r;
        ph = longint'(s.phase_deg);
        lf = longint'(s.log_freq);
        mg = longint'(s.mag_db);

        // Phase unwrap with a saturating turn count.
        if (sw_started) begin
            diff = ph + longint'(sw_turns) * TURN_UNITS - sw_prev_phase;
            while (diff > HALF_TURN && sw_turns > -TURN_LIMIT) begin
                sw_turns--;
                diff -= TURN_UNITS;
            end
            while (diff < -HALF_TURN && sw_turns < TURN_LIMIT) begin
                sw_turns++;
                diff += TURN_UNITS;
            end
        end
        unw = ph + longint'(sw_turns) * TURN_UNITS;
        if (sw_turns == TURN_LIMIT || sw_turns == -TURN_LIMIT)
            turn_limit_samples++;

        // First crossings of -180 degrees and of 0 dB.
        if (sw_started) begin
            if (!gm_hit && find_cross(sw_prev_phase, unw, -HALF_TURN, sw_prev_freq, lf,
                                      sw_prev_mag, mg, f, o)) begin
                g = -o;
                if (g > GAIN_MAX)
                    g = GAIN_MAX;
                gm_hit = 1'b1;
                gm_freq = f;
                gm_db = g;
            end
            if (!pm_hit && find_cross(sw_prev_mag, mg, 0, sw_prev_freq, lf,
                                      sw_prev_phase, unw, f, o)) begin
                pm_hit = 1'b1;
                pm_freq = f;
                pm_deg = HALF_TURN + o;
            end
        end

        sw_started = 1'b1;
        sw_prev_freq = lf;
        sw_prev_mag = mg;
        sw_prev_phase = unw;

        if (s.last_sample) begin
            r.gm_found    = gm_hit;
            r.gm_log_freq = LF_W'(gm_hit ? gm_freq : 64'sd0);
            r.gm_db       = MAG_W'(gm_hit ? gm_db : 64'sd0);
            r.pm_found    = pm_hit;
            r.pm_log_freq = LF_W'(pm_hit ? pm_freq : 64'sd0);
            r.pm_deg      = UNW_W'(pm_hit ? pm_deg : 64'sd0);
            r.stable      = (!gm_hit || gm_db > 0) && (!pm_hit || pm_deg > 0);
            expected_reports = {expected_reports, r};
            clear_sweep();
        end
    endtask

    task automatic compare_field(input string name, input logic signed [63:0] want,
                                 input logic signed [63:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            error_count++;
        end
    endtask

    // Checks one report beat against the oldest expectation.
    task automatic check_report(input margin_report_t got);
        margin_report_t want;
        if (expected_reports.size() == 0) begin
            $display("%0t: margin report with none expected, got %h", $time, got);
            error_count++;
        end
        else begin
            want = expected_reports.pop_front();
            compare_field("gain_margin_found", want.gm_found, got.gm_found);
            compare_field("gain_margin_log_freq", want.gm_log_freq, got.gm_log_freq);
            compare_field("gain_margin_db", want.gm_db, got.gm_db);
            compare_field("phase_margin_found", want.pm_found, got.pm_found);
            compare_field("phase_margin_log_freq", want.pm_log_freq, got.pm_log_freq);
            compare_field("phase_margin_deg", want.pm_deg, got.pm_deg);
            compare_field("stable", want.stable, got.stable);
            reports_checked++;
            gm_reports += want.gm_found;
            pm_reports += want.pm_found;
            unstable_reports += !want.stable;
        end
    endtask

    // Queues one sample, clamped to the field ranges.
    task automatic push_sample(input longint lf, input longint mg, input longint ph,
                               input bit last);
        sweep_sample_t s;
        s.log_freq    = LF_W'(clamp(lf, FIELD24_MIN, FIELD24_MAX));
        s.mag_db      = MAG_W'(clamp(mg, FIELD24_MIN, FIELD24_MAX));
        s.phase_deg   = PH_W'(clamp(ph, PHASE_MIN, PHASE_MAX));
        s.last_sample = last;
        pending_samples = {pending_samples, s};
        samples_queued++;
    endtask

    // A plausible loop response: rising frequency, falling gain and phase,
    // with exact hits on 0 dB and -180 degrees now and then.
    task automatic queue_loop_sweep();
        int len;
        longint lf;
        longint mg;
        longint tru;
        len = (rnd(0, 9) == 0) ? int'(rnd(11, 40)) : int'(rnd(2, 10));
        lf = rnd(-300000, 100000);
        mg = rnd(-1500, 12000);
        tru = rnd(-9000, 3000);
        for (int i = 0; i < len; i++) begin
            if (i > 0) begin
                lf += rnd(1, 30000);
                mg -= rnd(-400, 3000);
                tru -= rnd(-500, 5000);
            end
            if (rnd(0, 15) == 0)
                mg = 0;
            if (rnd(0, 15) == 0)
                tru = -HALF_TURN;
            push_sample(lf, mg, principal(tru), i == len - 1);
        end
        random_queued += len;
    endtask

    // Short sweeps of unrelated full-range values.
    task automatic queue_noise_sweep();
        int len;
        len = int'(rnd(1, 6));
        for (int i = 0; i < len; i++)
            push_sample(rnd(FIELD24_MIN, FIELD24_MAX), rnd(FIELD24_MIN, FIELD24_MAX),
                        rnd(PHASE_MIN, PHASE_MAX), i == len - 1);
        random_queued += len;
    endtask

    // A phase that keeps turning one way until the turn count saturates.
    task automatic queue_spiral_sweep(input bit upward);
        longint lf;
        longint mg;
        longint tru;
        lf = rnd(-200000, 0);
        mg = rnd(2000, 8000);
        tru = rnd(-3000, 3000);
        for (int i = 0; i < SPIRAL_LEN; i++) begin
            if (i > 0) begin
                lf += rnd(1, 2000);
                mg -= rnd(0, 60);
                tru += upward ? rnd(9000, 11400) : -rnd(9000, 11400);
            end
            push_sample(lf, mg, principal(tru), i == SPIRAL_LEN - 1);
        end
        random_queued += SPIRAL_LEN;
    endtask

    task automatic queue_random_sweep();
        if (rnd(0, 9) < 7)
            queue_loop_sweep();
        else
            queue_noise_sweep();
    endtask

    // Holds until every queued sample is taken and every report has come.
    task automatic wait_until_quiet();
        while (samples_taken != samples_queued || expected_reports.size() != 0)
            @(negedge clk);
    endtask

    // Cycle limit.
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: run exceeded %0d cycles", $time, CYCLE_LIMIT);
            $display("simulation failed");
            $finish;
        end
    end

    // Monitor: check report beats, then predict from sweep beats.
    always @(posedge clk) begin
        if (rst_n) begin
            if (report_ch.valid && report_ch.ready) begin
                seen_report.gm_found    = report_ch.gain_margin_found;
                seen_report.gm_log_freq = report_ch.gain_margin_log_freq;
                seen_report.gm_db       = report_ch.gain_margin_db;
                seen_report.pm_found    = report_ch.phase_margin_found;
                seen_report.pm_log_freq = report_ch.phase_margin_log_freq;
                seen_report.pm_deg      = report_ch.phase_margin_deg;
                seen_report.stable      = report_ch.stable;
                check_report(seen_report);
            end
            if (sweep_ch.valid && sweep_ch.ready) begin
                taken_sample.log_freq    = sweep_ch.log_freq;
                taken_sample.mag_db      = sweep_ch.mag_db;
                taken_sample.phase_deg   = sweep_ch.phase_deg;
                taken_sample.last_sample = sweep_ch.last_sample;
                track_sweep_sample(taken_sample);
                samples_taken++;
                beat_taken = 1'b1;
            end
        end
    end

    // Driver: sweep beats from the pending queue, random gaps and stalls.
    always @(negedge clk) begin
        if (rst_n) begin
            if (!sweep_ch.valid || beat_taken) begin
                beat_taken = 1'b0;
                if (gap_left > 0) begin
                    gap_left--;
                    sweep_ch.valid <= 1'b0;
                end
                else if (pending_samples.size() > 0) begin
                    next_sample = pending_samples.pop_front();
                    sweep_ch.log_freq    <= next_sample.log_freq;
                    sweep_ch.mag_db      <= next_sample.mag_db;
                    sweep_ch.phase_deg   <= next_sample.phase_deg;
                    sweep_ch.last_sample <= next_sample.last_sample;
                    sweep_ch.valid       <= 1'b1;
                    gap_left = pick_idle(calm_in);
                end
                else begin
                    sweep_ch.valid <= 1'b0;
                end
            end

            // Report side back-pressure.
            if (stall_left > 0) begin
                stall_left--;
                report_ch.ready <= 1'b0;
            end
            else begin
                report_ch.ready <= 1'b1;
                stall_left = pick_idle(calm_out);
            end
        end
    end

    // Reset, stimulus and end of run.
    initial begin
        rst_n = 1'b0;
        sweep_ch.valid = 1'b0;
        sweep_ch.log_freq = '0;
        sweep_ch.mag_db = '0;
        sweep_ch.phase_deg = '0;
        sweep_ch.last_sample = 1'b0;
        report_ch.ready = 1'b0;
        error_count = 0;
        samples_queued = 0;
        samples_taken = 0;
        random_queued = 0;
        reports_checked = 0;
        gm_reports = 0;
        pm_reports = 0;
        unstable_reports = 0;
        turn_limit_samples = 0;
        cycle_count = 0;
        beat_taken = 1'b0;
        gap_left = 0;
        stall_left = 0;
        calm_in = 0;
        calm_out = 0;
        clear_sweep();

        repeat (3) @(negedge clk);
        rst_n <= 1'b1;

        // Single-sample sweeps, including the field extremes.
        push_sample(0, 0, 0, 1'b1);
        push_sample(FIELD24_MIN, FIELD24_MIN, PHASE_MIN, 1'b1);
        push_sample(FIELD24_MAX, FIELD24_MAX, PHASE_MAX, 1'b1);
        // Exact hits of 0 dB and -180 degrees on the earlier sample.
        push_sample(100, 0, -HALF_TURN, 1'b0);
        push_sample(200, -512, -11600, 1'b1);
        // Gain margin saturation at the extremes of frequency and magnitude.
        push_sample(FIELD24_MIN, FIELD24_MIN, -HALF_TURN, 1'b0);
        push_sample(FIELD24_MAX, FIELD24_MAX, 0, 1'b1);
        // Interpolated crossings with a wrap of the principal phase each way.
        push_sample(0, 1280, -3000, 1'b0);
        push_sample(65536, 256, -11000, 1'b0);
        push_sample(131072, -768, 11000, 1'b0);
        push_sample(196608, -2000, 5000, 1'b0);
        push_sample(262144, -2500, -11000, 1'b1);
        // Rounding ties, upward and downward in frequency.
        push_sample(0, 1, 0, 1'b0);
        push_sample(1, -1, 0, 1'b1);
        push_sample(0, 1, 0, 1'b0);
        push_sample(-1, -1, 0, 1'b1);
        // Phase outside the principal range.
        push_sample(0, 100, PHASE_MAX, 1'b0);
        push_sample(10, 50, PHASE_MIN, 1'b0);
        push_sample(20, -50, PHASE_MAX, 1'b1);
        // Rising gain through 0 dB and phase rising through -180 degrees.
        push_sample(-65536, -3000, -14000, 1'b0);
        push_sample(0, 3000, -9000, 1'b1);
        wait_until_quiet();

        // Random sweeps, a full pause, turn-limit spirals, then more sweeps.
        while (random_queued < FIRST_BATCH)
            queue_random_sweep();
        wait_until_quiet();
        queue_spiral_sweep(1'b0);
        queue_spiral_sweep(1'b1);
        while (random_queued < RANDOM_ITEMS)
            queue_random_sweep();

        wait_until_quiet();
        repeat (SETTLE_CYCLES) @(negedge clk);

        $display("Checked %0d margin reports from %0d sweep samples.",
                 reports_checked, samples_taken);
        $display("Gain crossings %0d, phase crossings %0d, unstable %0d, turn-limit samples %0d.",
                 gm_reports, pm_reports, unstable_reports, turn_limit_samples);
        if (error_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

### sim.f
rtl/bmf_pkg.sv
rtl/bmf_if.sv
rtl/bmf_interp.sv
rtl/bode_margin_finder.sv
rtl/bmf_checker.sv
tb/tb_bode_margin_finder.sv
